>>> design/kgk_pkg.sv
// Shared types and constants for the kernel k-means graph engine.
// No dependencies; every other file imports this package.
package kgk_pkg;

  // default sizes of the storage
  localparam int DEF_MAX_SAMPLES   = 1024;
  localparam int DEF_MAX_NEIGHBORS = 16;
  localparam int DEF_MAX_CLUSTERS  = 32;

  // fixed field widths
  localparam int ID_W     = 10;
  localparam int DIST_W   = 24;
  localparam int LABEL_W  = 5;
  localparam int SLOTIN_W = 4;
  localparam int PASS_W   = 16;
  localparam int SUM_W    = 64;
  localparam int CFG_W    = 24;

  // register reset values
  localparam logic [10:0]       RST_NUM_SAMPLES  = 11'd1024;
  localparam logic [5:0]        RST_NUM_CLUSTERS = 6'd2;
  localparam logic [PASS_W-1:0] RST_MAX_PASSES   = 16'd100;
  localparam logic [DIST_W-1:0] RST_FAR_DISTANCE = 24'd0;

  typedef enum logic [1:0] {
    MODE_NBR   = 2'd0,
    MODE_LABEL = 2'd1,
    MODE_RUN   = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_NUM_SAMPLES  = 2'd0,
    CFG_NUM_CLUSTERS = 2'd1,
    CFG_MAX_PASSES   = 2'd2,
    CFG_FAR_DISTANCE = 2'd3
  } cfg_idx_t;

  // end-of-run report from the run engine
  typedef struct packed {
    logic              done;
    logic [PASS_W-1:0] passes;
    logic              converged;
  } run_status_t;

endpackage

>>> design/kgk_store.sv
// Graph and label memories: neighbor entries, list lengths, labels.
// One write and one registered read port per memory. Uses kgk_pkg.
module kgk_store import kgk_pkg::*; #(
  parameter int MAX_SAMPLES   = DEF_MAX_SAMPLES,
  parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS,
  parameter int MAX_CLUSTERS  = DEF_MAX_CLUSTERS,
  localparam int SAMP_W = $clog2(MAX_SAMPLES),
  localparam int NB_AW  = $clog2(MAX_SAMPLES * MAX_NEIGHBORS),
  localparam int LEN_W  = $clog2(MAX_NEIGHBORS + 1),
  localparam int LAB_W  = $clog2(MAX_CLUSTERS)
) (
  input  logic              clk,
  input  logic              nb_we,
  input  logic [NB_AW-1:0]  nb_waddr,
  input  logic [ID_W-1:0]   nb_wid,
  input  logic [DIST_W-1:0] nb_wdist,
  input  logic [NB_AW-1:0]  nb_raddr,
  output logic [ID_W-1:0]   nb_rid,
  output logic [DIST_W-1:0] nb_rdist,
  input  logic              len_we,
  input  logic [SAMP_W-1:0] len_waddr,
  input  logic [LEN_W-1:0]  len_wdata,
  input  logic [SAMP_W-1:0] len_raddr,
  output logic [LEN_W-1:0]  len_rdata,
  input  logic              lab_we,
  input  logic [SAMP_W-1:0] lab_waddr,
  input  logic [LAB_W-1:0]  lab_wdata,
  input  logic [SAMP_W-1:0] lab_raddr,
  output logic [LAB_W-1:0]  lab_rdata
);

  logic [ID_W+DIST_W-1:0] nb_mem [MAX_SAMPLES*MAX_NEIGHBORS];
  logic [LEN_W-1:0]       len_mem [MAX_SAMPLES];
  logic [LAB_W-1:0]       lab_mem [MAX_SAMPLES];

  // neighbor entries
  always_ff @(posedge clk) begin
    if (nb_we) begin
      nb_mem[nb_waddr] <= {nb_wid, nb_wdist};
    end
    {nb_rid, nb_rdist} <= nb_mem[nb_raddr];
  end

  // list lengths
  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    len_rdata <= len_mem[len_raddr];
  end

  // labels
  always_ff @(posedge clk) begin
    if (lab_we) begin
      lab_mem[lab_waddr] <= lab_wdata;
    end
    lab_rdata <= lab_mem[lab_raddr];
  end

endmodule

>>> design/kgk_div.sv
// Signed quotient (x * 2^8) / d, truncated toward zero, low 64 bits.
// Restoring divider, one quotient bit per cycle. Uses kgk_pkg.
module kgk_div import kgk_pkg::*; #(
  parameter int DIV_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam int NUM_W = SUM_W + 8;
  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] num;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic             running;
  logic             neg;
  logic             zero;
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   rem_dif;
  logic [SUM_W-1:0] mag;

  assign mag     = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
  assign rem_sh  = {rem, num[NUM_W-1]};
  assign rem_dif = rem_sh - {1'b0, dsr};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= running && !start && (cnt == CNT_W'(NUM_W - 1));
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  // datapath: shift in one dividend bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (start) begin
      num  <= {mag, 8'd0};
      rem  <= '0;
      dsr  <= divisor;
      neg  <= dividend[SUM_W-1];
      zero <= (divisor == '0);
    end else if (running) begin
      if (!rem_dif[DIV_W]) begin
        rem <= rem_dif[DIV_W-1:0];
        num <= {num[NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DIV_W-1:0];
        num <= {num[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = zero ? '0 : (neg ? (~num[SUM_W-1:0] + 1'b1) : num[SUM_W-1:0]);

endmodule

>>> design/kgk_run.sv
// Run engine: label cleanup, cluster sizes and sums, reassignment passes.
// Holds per-cluster statistics; uses kgk_div and the memories in kgk_store.
module kgk_run import kgk_pkg::*; #(
  parameter int MAX_SAMPLES   = DEF_MAX_SAMPLES,
  parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS,
  parameter int MAX_CLUSTERS  = DEF_MAX_CLUSTERS,
  localparam int SAMP_W = $clog2(MAX_SAMPLES),
  localparam int NS_W   = $clog2(MAX_SAMPLES + 1),
  localparam int NB_AW  = $clog2(MAX_SAMPLES * MAX_NEIGHBORS),
  localparam int LEN_W  = $clog2(MAX_NEIGHBORS + 1),
  localparam int LAB_W  = $clog2(MAX_CLUSTERS),
  localparam int K_W    = $clog2(MAX_CLUSTERS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NS_W-1:0]   ns,
  input  logic [K_W-1:0]    k,
  input  logic [PASS_W-1:0] max_passes,
  input  logic [DIST_W-1:0] far,
  output logic [SAMP_W-1:0] lab_raddr,
  output logic              lab_we,
  output logic [SAMP_W-1:0] lab_waddr,
  output logic [LAB_W-1:0]  lab_wdata,
  input  logic [LAB_W-1:0]  lab_rdata,
  output logic [SAMP_W-1:0] len_raddr,
  input  logic [LEN_W-1:0]  len_rdata,
  output logic [NB_AW-1:0]  nb_raddr,
  input  logic [ID_W-1:0]   nb_rid,
  input  logic [DIST_W-1:0] nb_rdist,
  output run_status_t       status
);

  localparam int SLOT_W = $clog2(MAX_NEIGHBORS);
  localparam int SIZE_W = $clog2(MAX_SAMPLES + 2);
  localparam int ACC_W  = DIST_W + LEN_W;
  localparam int DF_W   = ((SIZE_W > LEN_W) ? SIZE_W : LEN_W) + 1;
  localparam int MUL_W  = DF_W + DIST_W + 1;
  localparam int ST_N   = 28;

  typedef enum logic [ST_N-1:0] {
    R_IDLE  = (28'd1 << 0),  R_CLR  = (28'd1 << 1),
    F_RD    = (28'd1 << 2),  F_UPD  = (28'd1 << 3),
    S_RD    = (28'd1 << 4),  S_LAT  = (28'd1 << 5),
    S_NRD   = (28'd1 << 6),  S_NLAT = (28'd1 << 7),
    S_NCHK  = (28'd1 << 8),  S_MUL  = (28'd1 << 9),
    S_ACC   = (28'd1 << 10), P_START = (28'd1 << 11),
    P_RD    = (28'd1 << 12), P_LAT  = (28'd1 << 13),
    P_NRD   = (28'd1 << 14), P_NLAT = (28'd1 << 15),
    P_NACC  = (28'd1 << 16), P_EVAL = (28'd1 << 17),
    P_CAND  = (28'd1 << 18), P_CMUL = (28'd1 << 19),
    P_LS    = (28'd1 << 20), P_CL   = (28'd1 << 21),
    P_D1    = (28'd1 << 22), P_D2   = (28'd1 << 23),
    P_MV0   = (28'd1 << 24), P_OLDL = (28'd1 << 25),
    P_MV1   = (28'd1 << 26), R_DONE = (28'd1 << 27)
  } run_state_t;

  run_state_t state;

  // per-cluster statistics
  logic [SIZE_W-1:0] size_q  [MAX_CLUSTERS];
  logic [SUM_W-1:0]  sum_q   [MAX_CLUSTERS];
  logic [SUM_W-1:0]  link_q  [MAX_CLUSTERS];
  logic [LEN_W-1:0]  hit_q   [MAX_CLUSTERS];
  logic              seen_q  [MAX_CLUSTERS];
  logic [LAB_W-1:0]  order_q [MAX_NEIGHBORS];

  logic [NS_W-1:0]   i;
  logic [LEN_W-1:0]  s;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  cnt;
  logic [LEN_W-1:0]  nseen;
  logic [LEN_W-1:0]  cidx;
  logic [ACC_W-1:0]  acc;
  logic [DIST_W-1:0] cur_dist;
  logic [DIST_W-1:0] self_d;
  logic [LAB_W-1:0]  c;
  logic [LAB_W-1:0]  cold;
  logic [LAB_W-1:0]  cc;
  logic [LAB_W-1:0]  best;
  logic [SUM_W-1:0]  best_cost;
  logic [SUM_W-1:0]  best_l;
  logic [SUM_W-1:0]  old_l;
  logic [SUM_W-1:0]  lcur;
  logic [SUM_W-1:0]  prod;
  logic [SUM_W-1:0]  q1;
  logic [SUM_W-1:0]  d2;
  logic [SIZE_W-1:0] dv2;
  logic [PASS_W-1:0] pass;
  logic              moved;

  logic [SAMP_W-1:0] i_a;
  logic [LEN_W-1:0]  s_inc;
  logic [LAB_W-1:0]  lab_fix;
  logic [DF_W-1:0]   mul_a;
  logic signed [MUL_W-1:0] mul_out;
  logic [SUM_W-1:0]  two_l;
  logic [SUM_W-1:0]  d1;
  logic [SIZE_W-1:0] dv1;
  logic [SUM_W-1:0]  d2_next;
  logic [SIZE_W-1:0] dv2_next;
  logic              div_start;
  logic [SUM_W-1:0]  div_a;
  logic [SIZE_W-1:0] div_d;
  logic              div_done;
  logic [SUM_W-1:0]  div_q;
  logic [SUM_W-1:0]  cost;

  assign i_a     = i[SAMP_W-1:0];
  assign s_inc   = s + LEN_W'(1);
  assign lab_fix = (lab_rdata >= k) ? '0 : lab_rdata;

  // memory addresses
  assign lab_raddr = (state == S_NLAT || state == P_NLAT) ? SAMP_W'(nb_rid) : i_a;
  assign len_raddr = i_a;
  assign nb_raddr  = NB_AW'(i_a) * NB_AW'(MAX_NEIGHBORS) + NB_AW'(s[SLOT_W-1:0]);

  // label writes: cleanup of stale labels, then moves
  always_comb begin
    lab_we    = 1'b0;
    lab_waddr = i_a;
    lab_wdata = '0;
    if (state == F_UPD && lab_rdata >= k) begin
      lab_we = 1'b1;
    end else if (state == P_MV1) begin
      lab_we    = 1'b1;
      lab_wdata = best;
    end
  end

  // shared multiplier: (size - hits) * far, signed
  always_comb begin
    case (state)
      S_MUL:   mul_a = DF_W'(size_q[c]) - DF_W'(cnt);
      P_CMUL:  mul_a = DF_W'(size_q[cc]) - DF_W'(hit_q[cc]);
      P_MV0:   mul_a = DF_W'(size_q[cold]) - (seen_q[cold] ? DF_W'(hit_q[cold]) : '0);
      default: mul_a = '0;
    endcase
  end
  assign mul_out = $signed(mul_a) * $signed({1'b0, far});

  // quotient operands for one candidate cluster
  assign two_l = {lcur[SUM_W-2:0], 1'b0};
  always_comb begin
    if (cc == cold) begin
      d1       = sum_q[cc];
      dv1      = size_q[cc];
      d2_next  = sum_q[cc] - (two_l - SUM_W'(self_d));
      dv2_next = size_q[cc] - SIZE_W'(1);
    end else begin
      d1       = sum_q[cc] + two_l + SUM_W'(self_d);
      dv1      = size_q[cc] + SIZE_W'(1);
      d2_next  = sum_q[cc];
      dv2_next = size_q[cc];
    end
  end

  assign div_start = (state == P_CL) || (state == P_D1 && div_done);
  assign div_a     = (state == P_CL) ? d1 : d2;
  assign div_d     = (state == P_CL) ? dv1 : dv2;
  assign cost      = q1 - div_q;

  kgk_div #(.DIV_W(SIZE_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= R_IDLE;
      status <= '0;
    end else begin
      status.done <= (state == R_DONE);
      case (state)
        R_IDLE: begin
          if (start) begin
            state <= R_CLR;
          end
        end
        R_CLR: begin
          for (int j = 0; j < MAX_CLUSTERS; j++) begin
            size_q[j] <= '0;
            sum_q[j]  <= '0;
          end
          i     <= '0;
          pass  <= '0;
          moved <= 1'b1;
          state <= F_RD;
        end
        // clear stale labels and count sizes
        F_RD: begin
          if (i < ns) begin
            state <= F_UPD;
          end else begin
            i     <= '0;
            state <= S_RD;
          end
        end
        F_UPD: begin
          size_q[lab_fix] <= size_q[lab_fix] + SIZE_W'(1);
          i               <= i + NS_W'(1);
          state           <= F_RD;
        end
        // within-cluster distance sums
        S_RD: begin
          state <= (i < ns) ? S_LAT : P_START;
        end
        S_LAT: begin
          c     <= lab_rdata;
          len   <= len_rdata;
          cnt   <= '0;
          acc   <= '0;
          s     <= '0;
          state <= (len_rdata == '0) ? S_MUL : S_NRD;
        end
        S_NRD: begin
          state <= S_NLAT;
        end
        S_NLAT: begin
          cur_dist <= nb_rdist;
          if (nb_rid < ns) begin
            state <= S_NCHK;
          end else begin
            s     <= s_inc;
            state <= (s_inc < len) ? S_NRD : S_MUL;
          end
        end
        S_NCHK: begin
          if (lab_rdata == c) begin
            cnt <= cnt + LEN_W'(1);
            acc <= acc + ACC_W'(cur_dist);
          end
          s     <= s_inc;
          state <= (s_inc < len) ? S_NRD : S_MUL;
        end
        S_MUL: begin
          prod  <= SUM_W'(mul_out);
          state <= S_ACC;
        end
        S_ACC: begin
          sum_q[c] <= sum_q[c] + SUM_W'(acc) + prod;
          i        <= i + NS_W'(1);
          state    <= S_RD;
        end
        // reassignment passes
        P_START: begin
          if (pass >= max_passes) begin
            state <= R_DONE;
          end else begin
            pass  <= pass + PASS_W'(1);
            moved <= 1'b0;
            i     <= '0;
            state <= P_RD;
          end
        end
        P_RD: begin
          if (i < ns) begin
            state <= P_LAT;
          end else if (moved) begin
            state <= P_START;
          end else begin
            state <= R_DONE;
          end
        end
        P_LAT: begin
          cold <= lab_rdata;
          len  <= len_rdata;
          if (size_q[lab_rdata] <= SIZE_W'(1) || len_rdata == '0) begin
            i     <= i + NS_W'(1);
            state <= P_RD;
          end else begin
            for (int j = 0; j < MAX_CLUSTERS; j++) begin
              seen_q[j] <= 1'b0;
            end
            nseen <= '0;
            s     <= '0;
            state <= P_NRD;
          end
        end
        P_NRD: begin
          state <= P_NLAT;
        end
        P_NLAT: begin
          cur_dist <= nb_rdist;
          if (s == '0) begin
            self_d <= nb_rdist;
          end
          if (nb_rid < ns) begin
            state <= P_NACC;
          end else begin
            s     <= s_inc;
            state <= (s_inc < len) ? P_NRD : P_EVAL;
          end
        end
        P_NACC: begin
          if (!seen_q[lab_rdata]) begin
            seen_q[lab_rdata]          <= 1'b1;
            order_q[nseen[SLOT_W-1:0]] <= lab_rdata;
            nseen                      <= nseen + LEN_W'(1);
            hit_q[lab_rdata]           <= LEN_W'(1);
            link_q[lab_rdata]          <= SUM_W'(cur_dist);
          end else begin
            hit_q[lab_rdata]  <= hit_q[lab_rdata] + LEN_W'(1);
            link_q[lab_rdata] <= link_q[lab_rdata] + SUM_W'(cur_dist);
          end
          s     <= s_inc;
          state <= (s_inc < len) ? P_NRD : P_EVAL;
        end
        P_EVAL: begin
          if (nseen == '0) begin
            i     <= i + NS_W'(1);
            state <= P_RD;
          end else begin
            cidx  <= '0;
            state <= P_CAND;
          end
        end
        P_CAND: begin
          cc    <= order_q[cidx[SLOT_W-1:0]];
          state <= P_CMUL;
        end
        P_CMUL: begin
          prod  <= SUM_W'(mul_out);
          state <= P_LS;
        end
        P_LS: begin
          lcur  <= link_q[cc] + prod;
          state <= P_CL;
        end
        P_CL: begin
          d2    <= d2_next;
          dv2   <= dv2_next;
          state <= P_D1;
        end
        P_D1: begin
          if (div_done) begin
            q1    <= div_q;
            state <= P_D2;
          end
        end
        P_D2: begin
          if (div_done) begin
            // first candidate wins ties
            if (cidx == '0 || $signed(cost) < $signed(best_cost)) begin
              best      <= cc;
              best_cost <= cost;
              best_l    <= lcur;
            end
            cidx  <= cidx + LEN_W'(1);
            state <= ((cidx + LEN_W'(1)) < nseen) ? P_CAND : P_MV0;
          end
        end
        P_MV0: begin
          if (best == cold) begin
            i     <= i + NS_W'(1);
            state <= P_RD;
          end else begin
            prod  <= SUM_W'(mul_out);
            state <= P_OLDL;
          end
        end
        P_OLDL: begin
          old_l <= (seen_q[cold] ? link_q[cold] : '0) + prod;
          state <= P_MV1;
        end
        P_MV1: begin
          size_q[cold] <= size_q[cold] - SIZE_W'(1);
          size_q[best] <= size_q[best] + SIZE_W'(1);
          sum_q[cold]  <= sum_q[cold] - ({old_l[SUM_W-2:0], 1'b0} - SUM_W'(self_d));
          sum_q[best]  <= sum_q[best] + {best_l[SUM_W-2:0], 1'b0} + SUM_W'(self_d);
          moved        <= 1'b1;
          i            <= i + NS_W'(1);
          state        <= P_RD;
        end
        R_DONE: begin
          status.passes    <= pass;
          status.converged <= (pass != '0) && !moved;
          state            <= R_IDLE;
        end
        default: begin
          state <= R_IDLE;
        end
      endcase
    end
  end

endmodule

>>> design/knn_graph_kernel_kmeans_top.sv
// Top level: configuration registers, command decode, result register.
// Instantiates kgk_store and kgk_run; uses kgk_pkg.
//
//  channel   | signals                                     | handshake
//  ----------+---------------------------------------------+-------------------------
//  command   | mode sample slot neighbor distance label    | start & !busy
//            | list_end                                    |
//  result    | label_out passes converged error            | done, one cycle, no stall
//  config    | cfg_index cfg_data                          | cfg_write, every edge
//
// Load, label and read commands access the memories, then register the
// result. A run walks every sample and neighbor list through the
// registered-read memories, and each candidate cluster costs two quotients
// in the bit-serial divider, which dominates. Reset is synchronous; the
// memories are not cleared. The result beat cannot be held off by the
// receiver.
module knn_graph_kernel_kmeans_top import kgk_pkg::*; #(
  parameter int MAX_SAMPLES   = DEF_MAX_SAMPLES,
  parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS,
  parameter int MAX_CLUSTERS  = DEF_MAX_CLUSTERS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          mode,
  input  logic [ID_W-1:0]     sample,
  input  logic [SLOTIN_W-1:0] slot,
  input  logic [ID_W-1:0]     neighbor,
  input  logic [DIST_W-1:0]   distance,
  input  logic [LABEL_W-1:0]  label,
  input  logic                list_end,
  output logic                done,
  output logic [LABEL_W-1:0]  label_out,
  output logic [PASS_W-1:0]   passes,
  output logic                converged,
  output logic                error
);

  localparam int SAMP_W = $clog2(MAX_SAMPLES);
  localparam int NS_W   = $clog2(MAX_SAMPLES + 1);
  localparam int NB_AW  = $clog2(MAX_SAMPLES * MAX_NEIGHBORS);
  localparam int LEN_W  = $clog2(MAX_NEIGHBORS + 1);
  localparam int LAB_W  = $clog2(MAX_CLUSTERS);
  localparam int K_W    = $clog2(MAX_CLUSTERS + 1);

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_RESP = 3'b010,
    T_RUN  = 3'b100
  } top_state_t;

  top_state_t state;

  logic [10:0]       num_samples;
  logic [5:0]        num_clusters;
  logic [PASS_W-1:0] max_passes;
  logic [DIST_W-1:0] far_distance;
  logic [PASS_W-1:0] last_passes;
  logic              last_converged;
  logic              rd_pend;
  logic              err_pend;

  logic              accept;
  logic              in_range;
  logic              slot_ok;
  logic              bad_label;
  logic              run_active;
  logic              run_start;
  logic [NS_W-1:0]   ns;
  logic [K_W-1:0]    k;
  run_status_t       run_st;

  logic [NB_AW-1:0]  nb_addr_cmd;
  logic [NB_AW-1:0]  run_nb_raddr;
  logic [NB_AW-1:0]  nb_raddr;
  logic [ID_W-1:0]   nb_rid;
  logic [DIST_W-1:0] nb_rdist;
  logic              nb_we;
  logic              len_we;
  logic [SAMP_W-1:0] run_len_raddr;
  logic [SAMP_W-1:0] len_raddr;
  logic [LEN_W-1:0]  len_rdata;
  logic              run_lab_we;
  logic [SAMP_W-1:0] run_lab_waddr;
  logic [LAB_W-1:0]  run_lab_wdata;
  logic [SAMP_W-1:0] run_lab_raddr;
  logic              lab_we;
  logic [SAMP_W-1:0] lab_waddr;
  logic [LAB_W-1:0]  lab_wdata;
  logic [SAMP_W-1:0] lab_raddr;
  logic [LAB_W-1:0]  lab_rdata;

  // command decode
  assign busy       = (state != T_IDLE);
  assign accept     = start && !busy;
  assign run_active = (state == T_RUN);
  assign in_range   = 32'(sample) < MAX_SAMPLES;
  assign slot_ok    = 32'(slot) < MAX_NEIGHBORS;
  assign bad_label  = (6'(label) >= num_clusters) || (32'(label) >= MAX_CLUSTERS);
  assign run_start  = accept && (mode_t'(mode) == MODE_RUN);

  // clipped counts for the run
  assign ns = (32'(num_samples) > MAX_SAMPLES) ? NS_W'(MAX_SAMPLES) : NS_W'(num_samples);
  always_comb begin
    if (32'(num_clusters) > MAX_CLUSTERS) begin
      k = K_W'(MAX_CLUSTERS);
    end else if (num_clusters == '0) begin
      k = K_W'(1);
    end else begin
      k = K_W'(num_clusters);
    end
  end

  // memory port sharing between commands and the run engine
  assign nb_addr_cmd = NB_AW'(sample) * NB_AW'(MAX_NEIGHBORS) + NB_AW'(slot);
  assign nb_we       = accept && (mode_t'(mode) == MODE_NBR) && in_range && slot_ok;
  assign len_we      = nb_we && list_end;
  assign nb_raddr    = run_nb_raddr;
  assign len_raddr   = run_len_raddr;
  assign lab_raddr   = run_active ? run_lab_raddr : SAMP_W'(sample);
  always_comb begin
    if (run_active) begin
      lab_we    = run_lab_we;
      lab_waddr = run_lab_waddr;
      lab_wdata = run_lab_wdata;
    end else begin
      lab_we    = accept && (mode_t'(mode) == MODE_LABEL) && !bad_label && in_range;
      lab_waddr = SAMP_W'(sample);
      lab_wdata = LAB_W'(label);
    end
  end

  kgk_store #(
    .MAX_SAMPLES   (MAX_SAMPLES),
    .MAX_NEIGHBORS (MAX_NEIGHBORS),
    .MAX_CLUSTERS  (MAX_CLUSTERS)
  ) u_store (
    .clk       (clk),
    .nb_we     (nb_we),
    .nb_waddr  (nb_addr_cmd),
    .nb_wid    (neighbor),
    .nb_wdist  (distance),
    .nb_raddr  (nb_raddr),
    .nb_rid    (nb_rid),
    .nb_rdist  (nb_rdist),
    .len_we    (len_we),
    .len_waddr (SAMP_W'(sample)),
    .len_wdata (LEN_W'(5'(slot) + 5'd1)),
    .len_raddr (len_raddr),
    .len_rdata (len_rdata),
    .lab_we    (lab_we),
    .lab_waddr (lab_waddr),
    .lab_wdata (lab_wdata),
    .lab_raddr (lab_raddr),
    .lab_rdata (lab_rdata)
  );

  kgk_run #(
    .MAX_SAMPLES   (MAX_SAMPLES),
    .MAX_NEIGHBORS (MAX_NEIGHBORS),
    .MAX_CLUSTERS  (MAX_CLUSTERS)
  ) u_run (
    .clk        (clk),
    .rst        (rst),
    .start      (run_start),
    .ns         (ns),
    .k          (k),
    .max_passes (max_passes),
    .far        (far_distance),
    .lab_raddr  (run_lab_raddr),
    .lab_we     (run_lab_we),
    .lab_waddr  (run_lab_waddr),
    .lab_wdata  (run_lab_wdata),
    .lab_rdata  (lab_rdata),
    .len_raddr  (run_len_raddr),
    .len_rdata  (len_rdata),
    .nb_raddr   (run_nb_raddr),
    .nb_rid     (nb_rid),
    .nb_rdist   (nb_rdist),
    .status     (run_st)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_samples  <= RST_NUM_SAMPLES;
      num_clusters <= RST_NUM_CLUSTERS;
      max_passes   <= RST_MAX_PASSES;
      far_distance <= RST_FAR_DISTANCE;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_NUM_SAMPLES:  num_samples  <= cfg_data[10:0];
        CFG_NUM_CLUSTERS: num_clusters <= cfg_data[5:0];
        CFG_MAX_PASSES:   max_passes   <= cfg_data[PASS_W-1:0];
        CFG_FAR_DISTANCE: far_distance <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // command sequencing and result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= T_IDLE;
      done           <= 1'b0;
      last_passes    <= '0;
      last_converged <= 1'b0;
      rd_pend        <= 1'b0;
      err_pend       <= 1'b0;
    end else begin
      done <= (state == T_RESP);
      case (state)
        T_IDLE: begin
          if (accept) begin
            rd_pend  <= (mode_t'(mode) == MODE_READ) && in_range;
            err_pend <= (mode_t'(mode) == MODE_LABEL) && bad_label;
            state    <= (mode_t'(mode) == MODE_RUN) ? T_RUN : T_RESP;
          end
        end
        T_RUN: begin
          if (run_st.done) begin
            last_passes    <= run_st.passes;
            last_converged <= run_st.converged;
            rd_pend        <= 1'b0;
            err_pend       <= 1'b0;
            state          <= T_RESP;
          end
        end
        T_RESP: begin
          label_out <= rd_pend ? LABEL_W'(lab_rdata) : '0;
          passes    <= last_passes;
          converged <= last_converged;
          error     <= err_pend;
          state     <= T_IDLE;
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

endmodule
